/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define USV_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("usv assertion failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define USV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("usv assertion failed");

`endif

/* rtl/usv_pkg.sv */
// Shared constants, codes and the result type of the URL stream validator.
package usv_pkg;

	localparam int MAX_URL_BYTES_DEF = 256;
	localparam int HOST_LIMIT_DEF    = 128;
	localparam int PREFIX_LIMIT_DEF  = 96;

	// parse phases
	localparam logic [1:0] PH_SCHEME = 2'd0;
	localparam logic [1:0] PH_HOST   = 2'd1;
	localparam logic [1:0] PH_PORT   = 2'd2;
	localparam logic [1:0] PH_PATH   = 2'd3;

	// port parse progress
	localparam logic [1:0] PP_START  = 2'd0;
	localparam logic [1:0] PP_SIGN   = 2'd1;
	localparam logic [1:0] PP_DIGITS = 2'd2;

	localparam logic [15:0] DEFAULT_PORT = 16'd443;
	localparam logic [16:0] PORT_SAT     = 17'd65536;
	localparam logic [19:0] PORT_MAX     = 20'd65535;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int SCHEME_LEN = 8;

	typedef struct packed {
		logic [6:0]  prefix_length;
		logic [7:0]  path_offset;
		logic [6:0]  host_chars;
		logic [15:0] port_number;
		logic        url_valid;
	} usv_result_t;

	localparam int RESULT_BITS = $bits(usv_result_t);
	localparam int TDATA_OUT_BITS = ((RESULT_BITS + 7) / 8) * 8;

endpackage

/* rtl/usv_in_stage.sv */
// Input register stage: takes one byte transfer and holds it until it is consumed.
module usv_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       last_s1
);

	logic take;

	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

endmodule

/* rtl/usv_step.sv */
// Per-character parse step: next parser state and the result for a final character.
module usv_step #(
	parameter int MAX_URL_BYTES = usv_pkg::MAX_URL_BYTES_DEF,
	parameter int HOST_LIMIT    = usv_pkg::HOST_LIMIT_DEF,
	parameter int PREFIX_LIMIT  = usv_pkg::PREFIX_LIMIT_DEF,
	localparam int BPW = $clog2(MAX_URL_BYTES + 1),
	localparam int AW  = $clog2(HOST_LIMIT + 1),
	localparam int PCW = $clog2(PREFIX_LIMIT + 1)
) (
	input  logic [7:0]           url_byte,
	input  logic                 last_byte,
	input  logic [BPW-1:0]       byte_position,
	input  logic [1:0]           parse_phase,
	input  logic [AW-1:0]        authority_count,
	input  logic [AW-1:0]        host_count,
	input  logic [16:0]          port_accumulator,
	input  logic [1:0]           port_progress,
	input  logic [PCW-1:0]       path_count,
	input  logic [23:0]          recent_path_chars,
	input  logic [1:0]           hex_digits_due,
	input  logic                 failure_seen,
	output logic [BPW-1:0]       byte_position_nx,
	output logic [1:0]           parse_phase_nx,
	output logic [AW-1:0]        authority_count_nx,
	output logic [AW-1:0]        host_count_nx,
	output logic [16:0]          port_accumulator_nx,
	output logic [1:0]           port_progress_nx,
	output logic [PCW-1:0]       path_count_nx,
	output logic [23:0]          recent_path_chars_nx,
	output logic [1:0]           hex_digits_due_nx,
	output logic                 failure_seen_nx,
	output usv_pkg::usv_result_t result
);

	localparam int W1   = (BPW > AW) ? BPW : AW;
	localparam int W2   = (W1 > PCW) ? W1 : PCW;
	localparam int WIDE = ((W2 > 8) ? W2 : 8) + 1;

	function automatic logic [7:0] scheme_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h68; // h
			3'd1:    ch = 8'h74; // t
			3'd2:    ch = 8'h74; // t
			3'd3:    ch = 8'h70; // p
			3'd4:    ch = 8'h73; // s
			3'd5:    ch = usv_pkg::CH_COLON;
			default: ch = usv_pkg::CH_SLASH;
		endcase
		return ch;
	endfunction

	function automatic logic is_digit(input logic [7:0] ch);
		return ch inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alnum(input logic [7:0] ch);
		return ch inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic is_hex(input logic [7:0] ch);
		return ch inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic is_space(input logic [7:0] ch);
		return (ch == usv_pkg::CH_SPACE) || (ch inside {[8'h09:8'h0D]});
	endfunction

	// authority must be non-empty with a host; a port must be complete and 1..65535
	function automatic logic authority_bad(input logic [AW-1:0] ac, input logic [AW-1:0] hc,
	                                       input logic [1:0] ph, input logic [1:0] pp,
	                                       input logic [16:0] pa);
		logic bad;
		bad = (ac == '0) || (hc == '0);
		if (ph == usv_pkg::PH_PORT &&
		    (pp != usv_pkg::PP_DIGITS || pa == 17'd0 || pa > 17'd65535)) begin
			bad = 1'b1;
		end
		return bad;
	endfunction

	logic [7:0]     c;
	logic [BPW-1:0] bp;
	logic [1:0]     ph;
	logic [AW-1:0]  ac;
	logic [AW-1:0]  hc;
	logic [16:0]    pa;
	logic [1:0]     pp;
	logic [PCW-1:0] pc;
	logic [23:0]    rc;
	logic [1:0]     hd;
	logic           fs;
	logic [19:0]    acc10;
	logic [PCW-1:0] prefix;
	logic [WIDE-1:0] offset_w;
	logic [WIDE-1:0] host_w;
	logic [WIDE-1:0] prefix_w;

	always_comb begin
		c   = url_byte;
		bp  = byte_position;
		ph  = parse_phase;
		ac  = authority_count;
		hc  = host_count;
		pa  = port_accumulator;
		pp  = port_progress;
		pc  = path_count;
		rc  = recent_path_chars;
		hd  = hex_digits_due;
		fs  = failure_seen;
		acc10    = ({3'b000, port_accumulator} << 3) + ({3'b000, port_accumulator} << 1)
		           + 20'(url_byte[3:0]);
		prefix   = '0;
		offset_w = '0;
		host_w   = '0;
		prefix_w = '0;
		result   = '0;

		if (bp < BPW'(usv_pkg::SCHEME_LEN)) begin
			if (c != scheme_char(bp[2:0])) begin
				fs = 1'b1;
			end
			if (bp == BPW'(usv_pkg::SCHEME_LEN - 1)) begin
				ph = usv_pkg::PH_HOST;
			end
		end else begin
			if (c == usv_pkg::CH_AT || c == usv_pkg::CH_QMARK || c == usv_pkg::CH_HASH) begin
				fs = 1'b1;
			end
			if (ph != usv_pkg::PH_PATH && c == usv_pkg::CH_SLASH) begin
				if (authority_bad(ac, hc, ph, pp, pa)) begin
					fs = 1'b1;
				end
				ph = usv_pkg::PH_PATH;
			end
			if (ph == usv_pkg::PH_PATH) begin
				if (pc < PCW'(PREFIX_LIMIT)) begin
					pc = pc + 1'b1;
				end
				if (pc >= PCW'(PREFIX_LIMIT)) begin
					fs = 1'b1;
				end
				if (hd != 2'd0) begin
					if (!is_hex(c)) begin
						fs = 1'b1;
					end
					hd = hd - 1'b1;
				end else if (c == usv_pkg::CH_PCT) begin
					hd = 2'd2;
				end else if (!(is_alnum(c) || c == usv_pkg::CH_SLASH || c == usv_pkg::CH_DASH ||
				               c == usv_pkg::CH_DOT || c == usv_pkg::CH_UNDER ||
				               c == usv_pkg::CH_TILDE)) begin
					fs = 1'b1;
				end
				if (c == usv_pkg::CH_SLASH) begin
					if (rc[7:0] == usv_pkg::CH_SLASH) begin
						fs = 1'b1;
					end
					if (rc[15:0] == {usv_pkg::CH_SLASH, usv_pkg::CH_DOT}) begin
						fs = 1'b1;
					end
					if (rc == {usv_pkg::CH_SLASH, usv_pkg::CH_DOT, usv_pkg::CH_DOT}) begin
						fs = 1'b1;
					end
				end
				rc = {rc[15:0], c};
			end else begin
				if (ac < AW'(HOST_LIMIT)) begin
					ac = ac + 1'b1;
				end
				if (ac >= AW'(HOST_LIMIT)) begin
					fs = 1'b1;
				end
				if (ph == usv_pkg::PH_HOST) begin
					if (c == usv_pkg::CH_COLON) begin
						ph = usv_pkg::PH_PORT;
					end else if (is_alnum(c) || c == usv_pkg::CH_DOT || c == usv_pkg::CH_DASH) begin
						if (hc < AW'(HOST_LIMIT)) begin
							hc = hc + 1'b1;
						end
					end else begin
						fs = 1'b1;
					end
				end else begin
					case (pp)
						usv_pkg::PP_START: begin
							if (is_space(c)) begin
								pp = usv_pkg::PP_START;
							end else if (c == usv_pkg::CH_PLUS) begin
								pp = usv_pkg::PP_SIGN;
							end else if (is_digit(c)) begin
								pa = 17'(c[3:0]);
								pp = usv_pkg::PP_DIGITS;
							end else begin
								fs = 1'b1;
							end
						end
						usv_pkg::PP_SIGN: begin
							if (is_digit(c)) begin
								pa = 17'(c[3:0]);
								pp = usv_pkg::PP_DIGITS;
							end else begin
								fs = 1'b1;
							end
						end
						usv_pkg::PP_DIGITS: begin
							if (is_digit(c)) begin
								pa = (acc10 > usv_pkg::PORT_MAX) ? usv_pkg::PORT_SAT : acc10[16:0];
							end else begin
								fs = 1'b1;
							end
						end
						default: begin
							fs = 1'b1;
						end
					endcase
				end
			end
		end

		if (bp < BPW'(MAX_URL_BYTES)) begin
			bp = bp + 1'b1;
		end

		if (last_byte) begin
			if (bp <= BPW'(usv_pkg::SCHEME_LEN) || bp >= BPW'(MAX_URL_BYTES)) begin
				fs = 1'b1;
			end
			case (ph)
				usv_pkg::PH_HOST, usv_pkg::PH_PORT: begin
					if (authority_bad(ac, hc, ph, pp, pa)) begin
						fs = 1'b1;
					end
				end
				usv_pkg::PH_PATH: begin
					if (hd != 2'd0 || rc[15:0] == {usv_pkg::CH_SLASH, usv_pkg::CH_DOT} ||
					    rc == {usv_pkg::CH_SLASH, usv_pkg::CH_DOT, usv_pkg::CH_DOT}) begin
						fs = 1'b1;
					end
				end
				default: begin
					fs = 1'b1;
				end
			endcase

			if (ph == usv_pkg::PH_PATH) begin
				offset_w = WIDE'(usv_pkg::SCHEME_LEN) + WIDE'(ac);
				prefix   = pc;
				if (rc[7:0] == usv_pkg::CH_SLASH && pc != '0) begin
					prefix = pc - 1'b1;
				end
			end else begin
				offset_w = WIDE'(bp);
			end
			host_w   = WIDE'(hc);
			prefix_w = WIDE'(prefix);

			if (!fs) begin
				result.url_valid     = 1'b1;
				result.port_number   = (pp == usv_pkg::PP_DIGITS) ? pa[15:0] : usv_pkg::DEFAULT_PORT;
				result.host_chars    = host_w[6:0];
				result.path_offset   = offset_w[7:0];
				result.prefix_length = prefix_w[6:0];
			end

			// every URL starts from a clean parser
			bp = '0;
			ph = usv_pkg::PH_SCHEME;
			ac = '0;
			hc = '0;
			pa = '0;
			pp = usv_pkg::PP_START;
			pc = '0;
			rc = '0;
			hd = '0;
			fs = 1'b0;
		end

		byte_position_nx     = bp;
		parse_phase_nx       = ph;
		authority_count_nx   = ac;
		host_count_nx        = hc;
		port_accumulator_nx  = pa;
		port_progress_nx     = pp;
		path_count_nx        = pc;
		recent_path_chars_nx = rc;
		hex_digits_due_nx    = hd;
		failure_seen_nx      = fs;
	end

endmodule

/* rtl/usv_out_stage.sv */
// Result register: holds one verdict until the downstream side takes it.
module usv_out_stage (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  usv_pkg::usv_result_t                   result,
	output logic                                   room,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [usv_pkg::TDATA_OUT_BITS-1:0]     m_tdata
);

	usv_pkg::usv_result_t result_q;

	assign room    = !m_tvalid || m_tready;
	assign m_tdata = usv_pkg::TDATA_OUT_BITS'(result_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

/* rtl/https_url_stream_validator_top.sv */
// Top level of the HTTPS URL stream validator: byte stream in, one verdict per URL out.
//
// channel | dir | payload                                          | handshake
// s_      | in  | tdata[7:0] url_byte, tlast = last_byte           | tvalid/tready
// m_      | out | tdata: valid, port, host len, path off, prefix   | tvalid/tready
//
// One byte per cycle sustained while each final byte finds room in the result register.
// A byte is registered, then parsed by the step logic into the parser registers; the
// final byte also loads the result register, which raises m_tvalid.
// arst_n clears the parser, both valid flags and returns to the scheme phase.
// Only a final byte waits on a full result register; all other bytes flow regardless
// of m_tready, and the parser clears itself after each final byte.
module https_url_stream_validator_top #(
	parameter int MAX_URL_BYTES = usv_pkg::MAX_URL_BYTES_DEF,
	parameter int HOST_LIMIT    = usv_pkg::HOST_LIMIT_DEF,
	parameter int PREFIX_LIMIT  = usv_pkg::PREFIX_LIMIT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,  // [7:0] url_byte
	input  logic                               s_tlast,  // last_byte
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] url_valid, [16:1] port_number, [23:17] host_chars,
	// [31:24] path_offset, [38:32] prefix_length, [39] zero
	output logic [usv_pkg::TDATA_OUT_BITS-1:0] m_tdata
);

	localparam int BPW = $clog2(MAX_URL_BYTES + 1);
	localparam int AW  = $clog2(HOST_LIMIT + 1);
	localparam int PCW = $clog2(PREFIX_LIMIT + 1);

	// stage 1 (registered input byte)
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       room;

	// parser state
	logic [BPW-1:0] byte_position_q;
	logic [1:0]     parse_phase_q;
	logic [AW-1:0]  authority_count_q;
	logic [AW-1:0]  host_count_q;
	logic [16:0]    port_accumulator_q;
	logic [1:0]     port_progress_q;
	logic [PCW-1:0] path_count_q;
	logic [23:0]    recent_path_chars_q;
	logic [1:0]     hex_digits_due_q;
	logic           failure_seen_q;

	logic [BPW-1:0] byte_position_nx;
	logic [1:0]     parse_phase_nx;
	logic [AW-1:0]  authority_count_nx;
	logic [AW-1:0]  host_count_nx;
	logic [16:0]    port_accumulator_nx;
	logic [1:0]     port_progress_nx;
	logic [PCW-1:0] path_count_nx;
	logic [23:0]    recent_path_chars_nx;
	logic [1:0]     hex_digits_due_nx;
	logic           failure_seen_nx;

	usv_pkg::usv_result_t result;

	// a final byte needs a free result register; other bytes always move on
	assign advance = valid_s1 && (!last_s1 || room);

	usv_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1)
	);

	usv_step #(
		.MAX_URL_BYTES (MAX_URL_BYTES),
		.HOST_LIMIT    (HOST_LIMIT),
		.PREFIX_LIMIT  (PREFIX_LIMIT)
	) u_step (
		.url_byte             (byte_s1),
		.last_byte            (last_s1),
		.byte_position        (byte_position_q),
		.parse_phase          (parse_phase_q),
		.authority_count      (authority_count_q),
		.host_count           (host_count_q),
		.port_accumulator     (port_accumulator_q),
		.port_progress        (port_progress_q),
		.path_count           (path_count_q),
		.recent_path_chars    (recent_path_chars_q),
		.hex_digits_due       (hex_digits_due_q),
		.failure_seen         (failure_seen_q),
		.byte_position_nx     (byte_position_nx),
		.parse_phase_nx       (parse_phase_nx),
		.authority_count_nx   (authority_count_nx),
		.host_count_nx        (host_count_nx),
		.port_accumulator_nx  (port_accumulator_nx),
		.port_progress_nx     (port_progress_nx),
		.path_count_nx        (path_count_nx),
		.recent_path_chars_nx (recent_path_chars_nx),
		.hex_digits_due_nx    (hex_digits_due_nx),
		.failure_seen_nx      (failure_seen_nx),
		.result               (result)
	);

	// parser registers advance once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q     <= '0;
			parse_phase_q       <= usv_pkg::PH_SCHEME;
			authority_count_q   <= '0;
			host_count_q        <= '0;
			port_accumulator_q  <= '0;
			port_progress_q     <= usv_pkg::PP_START;
			path_count_q        <= '0;
			recent_path_chars_q <= '0;
			hex_digits_due_q    <= '0;
			failure_seen_q      <= 1'b0;
		end else if (advance) begin
			byte_position_q     <= byte_position_nx;
			parse_phase_q       <= parse_phase_nx;
			authority_count_q   <= authority_count_nx;
			host_count_q        <= host_count_nx;
			port_accumulator_q  <= port_accumulator_nx;
			port_progress_q     <= port_progress_nx;
			path_count_q        <= path_count_nx;
			recent_path_chars_q <= recent_path_chars_nx;
			hex_digits_due_q    <= hex_digits_due_nx;
			failure_seen_q      <= failure_seen_nx;
		end
	end

	usv_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && last_s1),
		.result   (result),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* rtl/usv_checker.sv */
// Port-level checker for the URL stream validator, bound to the top level.
`include "assert_macros.svh"

module usv_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic [7:0]                         s_tdata,
	input logic                               s_tlast,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [usv_pkg::TDATA_OUT_BITS-1:0] m_tdata
);

	// a stalled verdict holds
	`USV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// a rejected URL reports all fields as zero
	`USV_ASSERT_NOW(a_reject_zero, m_tvalid && !m_tdata[0], m_tdata[38:1] == 38'd0)

	// an accepted URL always carries a usable port
	`USV_ASSERT_NOW(a_port_nonzero, m_tvalid && m_tdata[0], m_tdata[16:1] != 16'd0)

endmodule

bind https_url_stream_validator_top usv_checker u_usv_checker (.*);
